/* rtl/lds_pkg.sv */
// Shared types and constants for the LED delay shape table.
// Used by the register block, the decode stage, the divider cells and the top level.
package lds_pkg;

   localparam int MAX_LEDS = 512;

   localparam int TIME_W = 16;
   localparam int CNT_W  = 10;
   localparam int POS_W  = 9;
   localparam int MODE_W = 2;

   // Largest count the table can hold: MAX_LEDS, or what the count register can express.
   localparam int CNT_MAX = (MAX_LEDS < (2 ** CNT_W) - 1) ? MAX_LEDS : (2 ** CNT_W) - 1;
   localparam int IDX_W   = (CNT_MAX > 2) ? $clog2(CNT_MAX) : 1;
   localparam int PROD_W  = TIME_W + IDX_W;

   localparam int NUM_REGS = 6;
   localparam int ADDR_W   = $clog2(NUM_REGS * 4);
   localparam int DATA_W   = 32;

   // Pipeline depth from an accepted word to its result strobe.
   localparam int LATENCY = TIME_W + 3;

   typedef enum logic [2:0] {
      REG_START_TIME = 3'd0,
      REG_PEAK_TIME  = 3'd1,
      REG_END_TIME   = 3'd2,
      REG_LED_COUNT  = 3'd3,
      REG_SHAPE_MODE = 3'd4,
      REG_REVERSE    = 3'd5
   } reg_index_type;

   localparam logic [MODE_W-1:0] MODE_RAMP     = 2'd0;
   localparam logic [MODE_W-1:0] MODE_TRIANGLE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_WEDGE    = 2'd2;

   typedef struct packed {
      logic [TIME_W-1:0] start_time;
      logic [TIME_W-1:0] peak_time;
      logic [TIME_W-1:0] end_time;
      logic [CNT_W-1:0]  led_count;
      logic [MODE_W-1:0] shape_mode;
      logic              reverse;
   } cfg_type;

   // One segment lookup after decode: value = a +/- (mag * i) / d.
   typedef struct packed {
      logic              valid;
      logic              oor;
      logic [TIME_W-1:0] a;
      logic              neg;
      logic [TIME_W-1:0] mag;
      logic [IDX_W-1:0]  i;
      logic [IDX_W-1:0]  d;
   } dec_type;

   // Word travelling down the divider chain. work holds the dividend bits not yet
   // consumed in its upper part and the quotient bits produced so far in its lower part.
   typedef struct packed {
      logic              valid;
      logic              oor;
      logic [TIME_W-1:0] a;
      logic              neg;
      logic [IDX_W-1:0]  d;
      logic [IDX_W-1:0]  rem;
      logic [TIME_W-1:0] work;
   } cell_type;

endpackage

/* rtl/lds_csr.sv */
// Configuration registers of the LED delay shape table on an APB-style port.
// Depends on lds_pkg for the register map and the cfg_type bundle.
module lds_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [lds_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [lds_pkg::DATA_W-1:0] csr_pwdata,
   output logic [lds_pkg::DATA_W-1:0] csr_prdata,
   output logic                       csr_pready,
   output lds_pkg::cfg_type           cfg
);
   import lds_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   logic          wr_en;
   reg_index_type reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_sel    = reg_index_type'(csr_paddr[ADDR_W-1:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_START_TIME: cfg_in.start_time = csr_pwdata[TIME_W-1:0];
            REG_PEAK_TIME:  cfg_in.peak_time  = csr_pwdata[TIME_W-1:0];
            REG_END_TIME:   cfg_in.end_time   = csr_pwdata[TIME_W-1:0];
            REG_LED_COUNT:  cfg_in.led_count  = csr_pwdata[CNT_W-1:0];
            REG_SHAPE_MODE: cfg_in.shape_mode = csr_pwdata[MODE_W-1:0];
            REG_REVERSE:    cfg_in.reverse    = csr_pwdata[0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_time <= '0;
         cfg_ff.peak_time  <= '0;
         cfg_ff.end_time   <= '0;
         cfg_ff.led_count  <= CNT_W'(1);
         cfg_ff.shape_mode <= MODE_RAMP;
         cfg_ff.reverse    <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (reg_sel)
         REG_START_TIME: csr_prdata = DATA_W'(cfg_ff.start_time);
         REG_PEAK_TIME:  csr_prdata = DATA_W'(cfg_ff.peak_time);
         REG_END_TIME:   csr_prdata = DATA_W'(cfg_ff.end_time);
         REG_LED_COUNT:  csr_prdata = DATA_W'(cfg_ff.led_count);
         REG_SHAPE_MODE: csr_prdata = DATA_W'(cfg_ff.shape_mode);
         REG_REVERSE:    csr_prdata = DATA_W'(cfg_ff.reverse);
         default:        csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/lds_decode.sv */
// Decode stage: picks the linear segment, its offset and its divisor for one position.
// Depends on lds_pkg; its registered output feeds the multiply stage.
module lds_decode (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  logic [lds_pkg::POS_W-1:0] position,
   input  lds_pkg::cfg_type          cfg,
   output lds_pkg::dec_type          dec
);
   import lds_pkg::*;

   localparam logic [CNT_W-1:0] CNT_MAX_C = CNT_W'(CNT_MAX);
   localparam logic [CNT_W-1:0] ONE_C     = CNT_W'(1);
   localparam logic [CNT_W-1:0] TWO_C     = CNT_W'(2);

   dec_type           dec_ff;
   dec_type           dec_in;
   logic [CNT_W-1:0]  cnt;
   logic [CNT_W-1:0]  pos_ext;
   logic [CNT_W-1:0]  idx;
   logic [CNT_W-1:0]  half;
   logic [CNT_W+1:0]  ramp3;
   logic [CNT_W-1:0]  ramp;
   logic [CNT_W-1:0]  seg_i;
   logic [CNT_W-1:0]  seg_len;
   logic [CNT_W-1:0]  len_m1;
   logic [TIME_W-1:0] seg_a;
   logic [TIME_W-1:0] seg_b;
   logic              oor;

   always_comb begin
      cnt     = (cfg.led_count > CNT_MAX_C) ? CNT_MAX_C : cfg.led_count;
      pos_ext = CNT_W'(position);
      oor     = (pos_ext >= cnt);
      idx     = cfg.reverse ? (cnt - ONE_C - pos_ext) : pos_ext;
      half    = cnt >> 1;
      ramp3   = ({2'b00, cnt} + {1'b0, cnt, 1'b0}) >> 2;
      ramp    = ramp3[CNT_W-1:0];
      if (ramp < TWO_C) begin
         ramp = TWO_C;
      end
      if (ramp > cnt) begin
         ramp = cnt;
      end

      seg_a   = cfg.start_time;
      seg_b   = cfg.end_time;
      seg_i   = idx;
      seg_len = cnt;
      if (cnt == ONE_C) begin
         // A single entry always holds the start time.
         seg_b   = cfg.start_time;
         seg_i   = '0;
         seg_len = ONE_C;
      end else begin
         unique case (cfg.shape_mode)
            MODE_TRIANGLE: begin
               if (idx >= half) begin
                  seg_a   = cfg.peak_time;
                  seg_b   = cfg.end_time;
                  seg_i   = idx - half;
                  seg_len = cnt - half;
               end else begin
                  seg_b   = cfg.peak_time;
                  seg_len = half + ONE_C;
               end
            end
            MODE_WEDGE: begin
               if (idx < ramp) begin
                  seg_b   = cfg.peak_time;
                  seg_len = ramp;
               end else begin
                  seg_a   = cfg.peak_time;
                  seg_b   = cfg.peak_time;
                  seg_i   = '0;
                  seg_len = ONE_C;
               end
            end
            default: begin
               seg_len = cnt;
            end
         endcase
      end

      len_m1 = seg_len - ONE_C;
      // The offset never exceeds len-1, so a one-entry segment has offset zero and
      // a divisor of one gives the same result without a zero divisor in the chain.
      if (oor || len_m1 == '0) begin
         len_m1 = ONE_C;
      end
      if (oor) begin
         seg_i = '0;
      end

      dec_in.valid = accept;
      dec_in.oor   = oor;
      dec_in.a     = seg_a;
      dec_in.neg   = (seg_b < seg_a);
      dec_in.mag   = (seg_b < seg_a) ? (seg_a - seg_b) : (seg_b - seg_a);
      dec_in.i     = seg_i[IDX_W-1:0];
      dec_in.d     = len_m1[IDX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dec_ff <= '0;
      end else begin
         dec_ff <= dec_in;
      end
   end

   assign dec = dec_ff;

endmodule

/* rtl/lds_div_cell.sv */
// One cell of the divider chain: a single restoring-division step per cycle.
// Depends on lds_pkg for cell_type; cells are chained in the top level.
module lds_div_cell (
   input  logic              clock,
   input  logic              reset,
   input  lds_pkg::cell_type prev,
   output lds_pkg::cell_type cell_out
);
   import lds_pkg::*;

   cell_type         stage_ff;
   cell_type         stage_in;
   logic [IDX_W:0]   trial;
   logic [IDX_W:0]   diff;
   logic             take;

   always_comb begin
      trial    = {prev.rem, prev.work[TIME_W-1]};
      diff     = trial - {1'b0, prev.d};
      take     = (trial >= {1'b0, prev.d});
      stage_in = prev;
      // The partial remainder stays below the divisor, so both choices fit IDX_W bits.
      stage_in.rem  = take ? diff[IDX_W-1:0] : trial[IDX_W-1:0];
      stage_in.work = {prev.work[TIME_W-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   assign cell_out = stage_ff;

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      stage_ff.valid |-> (stage_ff.rem < stage_ff.d))
      else $error("divider cell remainder is not below the divisor");

endmodule

/* rtl/led_delay_shape_table.sv */
// LED delay shape table: returns one entry of a ramp, triangle or wedge delay shape.
// Pipeline: an accepted word passes the decode and multiply registers, then 16 divider
// cells with one quotient bit per cell, then the final add register that drives the strobe.
// Throughput: one word per cycle; busy is high only during reset.
// Reset: synchronous; clears the pipeline valid bits and loads the register reset values.
module led_delay_shape_table (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [lds_pkg::POS_W-1:0]  req_position,
   output logic                       rsp_strobe,
   output logic [lds_pkg::TIME_W-1:0] rsp_delay_value,
   output logic                       rsp_out_of_range,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [lds_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [lds_pkg::DATA_W-1:0] csr_pwdata,
   output logic [lds_pkg::DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);
   import lds_pkg::*;

   cfg_type           cfg;
   dec_type           dec;
   cell_type          mul_ff;
   cell_type          mul_in;
   cell_type          chain [TIME_W+1];
   logic [PROD_W-1:0] prod;
   logic [TIME_W-1:0] quot;
   logic              accept;
   logic              strobe_ff;
   logic              strobe_in;
   logic [TIME_W-1:0] value_ff;
   logic [TIME_W-1:0] value_in;
   logic              oor_ff;
   logic              oor_in;

   assign busy   = reset;
   assign accept = start & ~busy;

   lds_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   lds_decode u_decode (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .position (req_position),
      .cfg      (cfg),
      .dec      (dec)
   );

   // Multiply stage: the scaled span becomes the dividend of the cell chain.
   always_comb begin
      prod          = PROD_W'(dec.mag) * PROD_W'(dec.i);
      mul_in.valid  = dec.valid;
      mul_in.oor    = dec.oor;
      mul_in.a      = dec.a;
      mul_in.neg    = dec.neg;
      mul_in.d      = dec.d;
      mul_in.rem    = prod[PROD_W-1:TIME_W];
      mul_in.work   = prod[TIME_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ff <= '0;
      end else begin
         mul_ff <= mul_in;
      end
   end

   assign chain[0] = mul_ff;

   for (genvar k = 0; k < TIME_W; k++) begin : g_cell
      lds_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .prev     (chain[k]),
         .cell_out (chain[k+1])
      );
   end

   // Truncation toward zero: the magnitude quotient is applied with the span's sign.
   always_comb begin
      quot      = chain[TIME_W].work;
      strobe_in = chain[TIME_W].valid;
      oor_in    = chain[TIME_W].oor;
      if (chain[TIME_W].oor) begin
         value_in = '0;
      end else if (chain[TIME_W].neg) begin
         value_in = chain[TIME_W].a - quot;
      end else begin
         value_in = chain[TIME_W].a + quot;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      oor_ff   <= oor_in;
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_delay_value  = value_ff;
   assign rsp_out_of_range = oor_ff;

   a_strobe_follows_accept: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_strobe)
      else $error("accepted word produced no result strobe");

   a_strobe_has_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, LATENCY))
      else $error("result strobe does not match an accepted word");

   a_oor_zero_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_out_of_range) |-> (rsp_delay_value == '0))
      else $error("out-of-range result carries a nonzero value");

   a_offset_within_segment: assert property (@(posedge clock) disable iff (reset)
      dec.valid |-> (dec.i <= dec.d && dec.d != '0))
      else $error("decoded segment offset exceeds its divisor");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the LED delay shape table: a queue-fed driver, an APB
// register writer with read-back and a monitor that checks each result strobe.
// Depends on lds_pkg and led_delay_shape_table from the rtl folder.
module tb_top;
   import lds_pkg::*;

   localparam logic [MODE_W-1:0] MODE_UNDEFINED = 2'd3;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int RANDOM_WORDS = 1000;

   typedef struct packed {
      logic [POS_W-1:0]  position;
      logic [TIME_W-1:0] delay_value;
      logic              out_of_range;
   } table_entry_type;

   logic clock;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [POS_W-1:0] req_position = '0;
   logic rsp_strobe;
   logic [TIME_W-1:0] rsp_delay_value;
   logic rsp_out_of_range;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [ADDR_W-1:0] csr_paddr = '0;
   logic [DATA_W-1:0] csr_pwdata = '0;
   logic [DATA_W-1:0] csr_prdata;
   logic csr_pready;

   // Shadow copy of the configuration registers, at their reset values.
   logic [TIME_W-1:0] cfg_start = '0;
   logic [TIME_W-1:0] cfg_peak = '0;
   logic [TIME_W-1:0] cfg_end = '0;
   logic [CNT_W-1:0]  cfg_count = 10'd1;
   logic [MODE_W-1:0] cfg_mode = MODE_RAMP;
   logic              cfg_reverse = 1'b0;

   logic [POS_W-1:0] pending_positions[$];
   table_entry_type expected_entries[$];
   logic word_taken = 1'b0;
   int unsigned gap_left = 0;
   bit gaps_enabled = 1'b1;
   int failures = 0;
   int idle_cycles = 0;

   led_delay_shape_table dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Entry i of a straight segment from a to b over len entries, truncated toward zero.
   function automatic logic [TIME_W-1:0] segment_point(int unsigned a, int unsigned b,
                                                       int unsigned i, int unsigned len);
      longint span;
      longint scaled;
      if (len <= 1) return TIME_W'(a);
      span = longint'(b) - longint'(a);
      scaled = (span * longint'(i)) / longint'(len - 1);
      return TIME_W'(longint'(a) + scaled);
   endfunction

   function automatic table_entry_type shape_entry(logic [POS_W-1:0] pos);
      table_entry_type entry;
      int unsigned count;
      int unsigned idx;
      int unsigned half;
      int unsigned rise;
      count = cfg_count;
      if (count > MAX_LEDS) count = MAX_LEDS;
      entry.position = pos;
      entry.delay_value = '0;
      entry.out_of_range = 1'b1;
      if (pos >= count) return entry;
      entry.out_of_range = 1'b0;
      idx = cfg_reverse ? count - 1 - pos : pos;
      if (count == 1) begin
         entry.delay_value = cfg_start;
      end else begin
         case (cfg_mode)
            MODE_TRIANGLE: begin
               half = count / 2;
               if (idx >= half)
                  entry.delay_value = segment_point(cfg_peak, cfg_end, idx - half, count - half);
               else
                  entry.delay_value = segment_point(cfg_start, cfg_peak, idx, half + 1);
            end
            MODE_WEDGE: begin
               rise = count * 3 / 4;
               if (rise < 2) rise = 2;
               if (rise > count) rise = count;
               if (idx < rise)
                  entry.delay_value = segment_point(cfg_start, cfg_peak, idx, rise);
               else
                  entry.delay_value = cfg_peak;
            end
            default: begin
               entry.delay_value = segment_point(cfg_start, cfg_end, idx, count);
            end
         endcase
      end
      return entry;
   endfunction

   function automatic int unsigned next_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (!gaps_enabled || roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Driver: a word stays on the port until it is taken, then an optional gap follows.
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap_left <= 0;
      end else if (!start || word_taken) begin
         if (gap_left != 0) begin
            start <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (pending_positions.size() != 0) begin
            start <= 1'b1;
            req_position <= pending_positions.pop_front();
            gap_left <= next_gap();
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor, predictor and watchdog.
   always @(posedge clock) begin
      table_entry_type want;
      if (reset) begin
         word_taken <= 1'b0;
      end else begin
         if (rsp_strobe) begin
            if (expected_entries.size() == 0) begin
               $display("%0t: unexpected word, delay_value %0d out_of_range %0b", $time,
                        rsp_delay_value, rsp_out_of_range);
               failures++;
            end else begin
               want = expected_entries.pop_front();
               if (rsp_delay_value !== want.delay_value) begin
                  $display("%0t: position %0d delay_value expected %0d actual %0d", $time,
                           want.position, want.delay_value, rsp_delay_value);
                  failures++;
               end
               if (rsp_out_of_range !== want.out_of_range) begin
                  $display("%0t: position %0d out_of_range expected %0b actual %0b", $time,
                           want.position, want.out_of_range, rsp_out_of_range);
                  failures++;
               end
            end
         end
         word_taken <= start && !busy;
         if (start && !busy) expected_entries.push_back(shape_entry(req_position));
      end
      if ((start && !busy) || rsp_strobe || (csr_psel && csr_penable && csr_pready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Writes one register, then reads it back. Noisy writes put random values in the unused upper bits.
   task automatic program_register(reg_index_type r, logic [DATA_W-1:0] field_value,
                                   bit noisy);
      logic [DATA_W-1:0] mask;
      logic [DATA_W-1:0] word;
      case (r)
         REG_LED_COUNT:  mask = 32'h0000_03FF;
         REG_SHAPE_MODE: mask = 32'h0000_0003;
         REG_REVERSE:    mask = 32'h0000_0001;
         default:        mask = 32'h0000_FFFF;
      endcase
      word = ((noisy ? $urandom : 32'd0) & ~mask) | (field_value & mask);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= ADDR_W'({r, 2'b00});
      csr_pwdata <= word;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (r)
         REG_START_TIME: cfg_start = word[TIME_W-1:0];
         REG_PEAK_TIME:  cfg_peak = word[TIME_W-1:0];
         REG_END_TIME:   cfg_end = word[TIME_W-1:0];
         REG_LED_COUNT:  cfg_count = word[CNT_W-1:0];
         REG_SHAPE_MODE: cfg_mode = word[MODE_W-1:0];
         default:        cfg_reverse = word[0];
      endcase
      @(negedge clock);
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== (word & mask)) begin
         $display("%0t: register %0d read expected %0h actual %0h", $time, r, word & mask,
                  csr_prdata);
         failures++;
      end
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic configure(logic [TIME_W-1:0] s, logic [TIME_W-1:0] p, logic [TIME_W-1:0] e,
                            logic [CNT_W-1:0] cnt, logic [MODE_W-1:0] mode, logic rev,
                            bit noisy);
      program_register(REG_START_TIME, 32'(s), noisy);
      program_register(REG_PEAK_TIME, 32'(p), noisy);
      program_register(REG_END_TIME, 32'(e), noisy);
      program_register(REG_LED_COUNT, 32'(cnt), noisy);
      program_register(REG_SHAPE_MODE, 32'(mode), noisy);
      program_register(REG_REVERSE, 32'(rev), noisy);
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_positions.size() != 0 || start || expected_entries.size() != 0);
   endtask

   function automatic logic [TIME_W-1:0] pick_time();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return 16'hFFFF;
         default: return TIME_W'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic logic [CNT_W-1:0] pick_count();
      int unsigned roll;
      roll = $urandom_range(0, 19);
      if (roll == 0) return CNT_W'($urandom_range(0, 3));
      if (roll == 1) return CNT_W'(MAX_LEDS);
      if (roll == 2) return CNT_W'($urandom_range(MAX_LEDS + 1, 1023));
      if (roll < 9) return CNT_W'($urandom_range(1, 16));
      return CNT_W'($urandom_range(1, MAX_LEDS));
   endfunction

   function automatic logic [POS_W-1:0] pick_position();
      int unsigned eff;
      int unsigned roll;
      eff = (cfg_count > MAX_LEDS) ? MAX_LEDS : cfg_count;
      roll = $urandom_range(0, 99);
      if (eff == 0 || roll < 12) return POS_W'($urandom_range(0, 511));
      if (roll < 22) begin
         case ($urandom_range(0, 3))
            0: return '0;
            1: return POS_W'(eff - 1);
            2: return POS_W'(eff / 2);
            default: return (eff < MAX_LEDS) ? POS_W'(eff) : POS_W'(eff - 1);
         endcase
      end
      return POS_W'($urandom_range(0, eff - 1));
   endfunction

   initial begin
      int random_words;
      int phase_words;
      logic [MODE_W-1:0] mode;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset values: a count of one, so only position zero is in range.
      pending_positions = '{9'd0, 9'd1, 9'd511};
      wait_drained();
      configure(16'd0, 16'd0, 16'hFFFF, 10'd512, MODE_RAMP, 1'b0, 1'b0);
      pending_positions = '{9'd0, 9'd511, 9'd256};
      wait_drained();
      // Triangle falling to zero and back up to full scale.
      configure(16'hFFFF, 16'd0, 16'hFFFF, 10'd7, MODE_TRIANGLE, 1'b0, 1'b0);
      pending_positions = '{9'd0, 9'd2, 9'd3, 9'd6, 9'd7};
      wait_drained();
      // Reversed wedge across the end of the rise and into the plateau.
      configure(16'd100, 16'd40000, 16'd0, 10'd9, MODE_WEDGE, 1'b1, 1'b0);
      pending_positions = '{9'd0, 9'd5, 9'd6, 9'd8, 9'd9};
      wait_drained();
      configure(16'd1234, 16'd0, 16'd0, 10'd0, MODE_RAMP, 1'b0, 1'b0);
      pending_positions = '{9'd0};
      wait_drained();
      // Count above the table size saturates, and the undefined mode acts as a ramp.
      configure(16'd500, 16'd0, 16'd9, 10'd1023, MODE_UNDEFINED, 1'b1, 1'b0);
      pending_positions = '{9'd0, 9'd511};
      wait_drained();
      configure(16'd777, 16'hFFFF, 16'd0, 10'd1, MODE_WEDGE, 1'b0, 1'b0);
      pending_positions = '{9'd0, 9'd1};
      wait_drained();
      configure(16'd1000, 16'hFFFF, 16'd2000, 10'd2, MODE_WEDGE, 1'b0, 1'b0);
      pending_positions = '{9'd0, 9'd1};
      wait_drained();

      random_words = 0;
      while (random_words < RANDOM_WORDS) begin
         mode = ($urandom_range(0, 9) == 0) ? MODE_UNDEFINED : MODE_W'($urandom_range(0, 2));
         configure(pick_time(), pick_time(), pick_time(), pick_count(), mode,
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         gaps_enabled = ($urandom_range(0, 3) != 0);
         phase_words = $urandom_range(10, 40);
         repeat (phase_words) pending_positions.push_back(pick_position());
         random_words += phase_words;
         wait_drained();
      end

      repeat (LATENCY + 5) @(negedge clock);
      if (failures == 0 && expected_entries.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
